FILE: rtl/tlkmc_pkg.sv
// Shared types, constants and defaults for the keyed memo cache.
`default_nettype none
package tlkmc_pkg;

	localparam int unsigned KEY_W       = 64;
	localparam int unsigned VAL_W       = 64;
	localparam int unsigned LEVEL_W     = 2;
	localparam int unsigned VCNT_W      = 5;
	localparam int unsigned OUT_CNT_W   = 32;

	localparam int unsigned FAR_DEPTH_DEF   = 16;
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	localparam logic [KEY_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [KEY_W-1:0] FNV_BASIS   = 64'hcbf2_9ce4_8422_2325;
	localparam int unsigned      SHL_AMT     = 6;
	localparam int unsigned      SHR_AMT     = 2;

	localparam logic [LEVEL_W-1:0] LVL_NEAR = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_FAR  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_MISS = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} far_entry_t;

	typedef enum logic [1:0] {
		ALU_SEED,
		ALU_SHIFT,
		ALU_FOLD
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_SHIFT,
		ST_FOLD,
		ST_NEAR,
		ST_READ,
		ST_MATCH,
		ST_MISS
	} st_t;

endpackage
`default_nettype wire

FILE: rtl/tlkmc_alu.sv
// Shared 64-bit adder for the three hash-combine steps.
`default_nettype none
module tlkmc_alu (
	input  wire tlkmc_pkg::alu_op_t              op,
	input  wire logic [tlkmc_pkg::KEY_W-1:0]     word,
	input  wire logic [tlkmc_pkg::KEY_W-1:0]     acc,
	input  wire logic [tlkmc_pkg::KEY_W-1:0]     fp,
	output logic      [tlkmc_pkg::KEY_W-1:0]     res
);
	import tlkmc_pkg::*;

	logic [KEY_W-1:0] add_a;
	logic [KEY_W-1:0] add_b;
	logic [KEY_W-1:0] sum;

	always_comb begin
		unique case (op)
			ALU_SEED: begin
				add_a = word;
				add_b = GOLDEN_STEP;
			end
			ALU_SHIFT: begin
				add_a = acc;
				add_b = fp << SHL_AMT;
			end
			ALU_FOLD: begin
				add_a = acc;
				add_b = fp >> SHR_AMT;
			end
			default: begin
				add_a = word;
				add_b = GOLDEN_STEP;
			end
		endcase
	end

	assign sum = add_a + add_b;
	assign res = (op == ALU_FOLD) ? (fp ^ sum) : sum;

endmodule
`default_nettype wire

FILE: rtl/tlkmc_far_mem.sv
// Far cache storage: one write port, one registered read port.
`default_nettype none
module tlkmc_far_mem #(
	parameter int unsigned FAR_DEPTH = tlkmc_pkg::FAR_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(FAR_DEPTH)
) (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [IDX_W-1:0]        wr_addr,
	input  wire tlkmc_pkg::far_entry_t   wr_data,
	input  wire logic [IDX_W-1:0]        rd_addr,
	output tlkmc_pkg::far_entry_t        rd_data
);
	import tlkmc_pkg::*;

	far_entry_t mem [FAR_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

FILE: rtl/two_level_keyed_memo_cache_core.sv
// Top level: sequencer, near entry, counters and result registers of the memo cache.
//
// Each key word is accepted when start is high and busy is low, and is folded
// into the fingerprint by three passes through one shared 64-bit adder, in the
// seed, shift and fold states; a word that is not last then returns to idle. On
// the last word the near entry is checked in the near state; on a near miss the
// filled far entries are probed in index order from slot 0, each by a read state
// and a match state through the single read port of the far store, and a miss
// then writes the far store in one more state. The result beat is shown for exactly
// one cycle with done high, in the first cycle that busy is low again; the
// receiver cannot stall it and must take it then.
`default_nettype none
module two_level_keyed_memo_cache_core #(
	parameter int unsigned FAR_DEPTH   = tlkmc_pkg::FAR_DEPTH_DEF,
	parameter int unsigned COUNT_WIDTH = tlkmc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [tlkmc_pkg::KEY_W-1:0]          key_word,
	input  wire logic                                 last,
	input  wire logic [tlkmc_pkg::VAL_W-1:0]          miss_value,
	output logic                                      done,
	output logic      [tlkmc_pkg::VAL_W-1:0]          cached_value,
	output logic      [tlkmc_pkg::LEVEL_W-1:0]        hit_level,
	output logic      [tlkmc_pkg::OUT_CNT_W-1:0]      l1_hit_total,
	output logic      [tlkmc_pkg::OUT_CNT_W-1:0]      l2_hit_total,
	output logic      [tlkmc_pkg::OUT_CNT_W-1:0]      miss_total,
	output logic      [tlkmc_pkg::VCNT_W-1:0]         l2_valid_count
);
	import tlkmc_pkg::*;

	localparam int unsigned IDX_W  = $clog2(FAR_DEPTH);
	localparam int unsigned FILL_W = $clog2(FAR_DEPTH + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FAR_DEPTH);
	localparam logic [IDX_W-1:0]  SLOT_LAST = IDX_W'(FAR_DEPTH - 1);

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		sat_inc = (c == '1) ? c : c + COUNT_WIDTH'(1);
	endfunction

	function automatic logic [OUT_CNT_W-1:0] sat32(input logic [COUNT_WIDTH-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		sat32 = (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_CNT_W-1:0];
	endfunction

	function automatic logic [VCNT_W-1:0] sat_vcnt(input logic [FILL_W-1:0] f);
		logic [31:0] w;
		w = 32'(f);
		sat_vcnt = (w > 32'd31) ? '1 : w[VCNT_W-1:0];
	endfunction

	st_t state_q, state_d;
	alu_op_t alu_op;

	logic [KEY_W-1:0]       word_q;
	logic [VAL_W-1:0]       miss_value_q;
	logic                   last_q;
	logic [KEY_W-1:0]       acc_q;
	logic [KEY_W-1:0]       fp_q;
	logic [KEY_W-1:0]       key_q;
	logic [KEY_W-1:0]       alu_res;

	logic                   near_valid_q;
	logic [KEY_W-1:0]       near_key_q;
	logic [VAL_W-1:0]       near_value_q;

	logic [IDX_W-1:0]       slot_q;
	logic [IDX_W-1:0]       slot_nx;
	logic [FILL_W-1:0]      fill_q, fill_d;
	logic [IDX_W-1:0]       idx_q;

	logic [COUNT_WIDTH-1:0] near_hits_q, near_hits_d;
	logic [COUNT_WIDTH-1:0] far_hits_q, far_hits_d;
	logic [COUNT_WIDTH-1:0] miss_cnt_q, miss_cnt_d;

	logic                   done_q;
	logic [KEY_W-1:0]       cmp_lhs;
	logic                   key_eq;
	logic                   near_hit;
	logic                   last_probe;

	far_entry_t             wr_entry;
	far_entry_t             rd_entry;

	tlkmc_alu u_alu (
		.op   (alu_op),
		.word (word_q),
		.acc  (acc_q),
		.fp   (fp_q),
		.res  (alu_res)
	);

	assign wr_entry = '{key: key_q, value: miss_value_q};

	tlkmc_far_mem #(
		.FAR_DEPTH (FAR_DEPTH)
	) u_far_mem (
		.clk     (clk),
		.wr_en   (state_q == ST_MISS),
		.wr_addr (slot_q),
		.wr_data (wr_entry),
		.rd_addr (idx_q),
		.rd_data (rd_entry)
	);

	assign cmp_lhs    = (state_q == ST_NEAR) ? near_key_q : rd_entry.key;
	assign key_eq     = (cmp_lhs == key_q);
	assign near_hit   = near_valid_q && key_eq;
	assign last_probe = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);
	assign slot_nx    = (slot_q == SLOT_LAST) ? '0 : slot_q + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		alu_op      = ALU_SEED;
		near_hits_d = near_hits_q;
		far_hits_d  = far_hits_q;
		miss_cnt_d  = miss_cnt_q;
		fill_d      = fill_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				alu_op  = ALU_SHIFT;
				state_d = ST_FOLD;
			end
			ST_FOLD: begin
				alu_op  = ALU_FOLD;
				state_d = last_q ? ST_NEAR : ST_IDLE;
			end
			ST_NEAR: begin
				if (near_hit) begin
					near_hits_d = sat_inc(near_hits_q);
					state_d     = ST_IDLE;
				end else if (fill_q == '0) begin
					state_d = ST_MISS;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MATCH;
			end
			ST_MATCH: begin
				if (key_eq) begin
					far_hits_d = sat_inc(far_hits_q);
					state_d    = ST_IDLE;
				end else if (last_probe) begin
					state_d = ST_MISS;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_MISS: begin
				miss_cnt_d = sat_inc(miss_cnt_q);
				if (fill_q != FILL_MAX) begin
					fill_d = fill_q + FILL_W'(1);
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q         <= FNV_BASIS;
			last_q       <= 1'b0;
			near_valid_q <= 1'b0;
			slot_q       <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			near_hits_q  <= '0;
			far_hits_q   <= '0;
			miss_cnt_q   <= '0;
			done_q       <= 1'b0;
		end else begin
			near_hits_q <= near_hits_d;
			far_hits_q  <= far_hits_d;
			miss_cnt_q  <= miss_cnt_d;
			fill_q      <= fill_d;
			done_q      <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						last_q <= last;
					end
				end
				ST_FOLD: begin
					fp_q  <= last_q ? FNV_BASIS : alu_res;
					idx_q <= '0;
				end
				ST_NEAR: begin
					if (near_hit) begin
						done_q <= 1'b1;
					end
				end
				ST_MATCH: begin
					if (key_eq) begin
						near_valid_q <= 1'b1;
						done_q       <= 1'b1;
					end else if (!last_probe) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_MISS: begin
					near_valid_q <= 1'b1;
					slot_q       <= slot_nx;
					done_q       <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					word_q       <= key_word;
					miss_value_q <= miss_value;
				end
			end
			ST_SEED, ST_SHIFT: begin
				acc_q <= alu_res;
			end
			ST_FOLD: begin
				key_q <= alu_res;
			end
			ST_NEAR: begin
				if (near_hit) begin
					cached_value   <= near_value_q;
					hit_level      <= LVL_NEAR;
					l1_hit_total   <= sat32(near_hits_d);
					l2_hit_total   <= sat32(far_hits_d);
					miss_total     <= sat32(miss_cnt_d);
					l2_valid_count <= sat_vcnt(fill_d);
				end
			end
			ST_MATCH: begin
				if (key_eq) begin
					near_key_q     <= key_q;
					near_value_q   <= rd_entry.value;
					cached_value   <= rd_entry.value;
					hit_level      <= LVL_FAR;
					l1_hit_total   <= sat32(near_hits_d);
					l2_hit_total   <= sat32(far_hits_d);
					miss_total     <= sat32(miss_cnt_d);
					l2_valid_count <= sat_vcnt(fill_d);
				end
			end
			ST_MISS: begin
				near_key_q     <= key_q;
				near_value_q   <= miss_value_q;
				cached_value   <= miss_value_q;
				hit_level      <= LVL_MISS;
				l1_hit_total   <= sat32(near_hits_d);
				l2_hit_total   <= sat32(far_hits_d);
				miss_total     <= sat32(miss_cnt_d);
				l2_valid_count <= sat_vcnt(fill_d);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

`ifndef ASSERT_OFF
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without preceding work");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("far fill count beyond depth");

	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit_level == LVL_NEAR || hit_level == LVL_FAR || hit_level == LVL_MISS))
		else $error("bad hit level on result beat");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");
`endif

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the keyed memo cache core: directed table, pooled random keys, checked beat by beat.
`timescale 1ns / 100ps
module tb;
	import tlkmc_pkg::*;

	localparam int unsigned  ITEMS      = 600;
	localparam int unsigned  CALM_FROM  = 520;
	localparam int unsigned  DRAIN_AT   = 300;
	localparam int unsigned  POOL_KEYS  = 24;
	localparam int unsigned  FAR_SLOTS  = FAR_DEPTH_DEF;
	localparam int unsigned  TAIL       = 5 + 2 * FAR_DEPTH_DEF + 8;
	localparam int unsigned  LIMIT      = 400000;
	localparam logic [63:0]  ONES       = '1;

	typedef struct packed {
		logic [VAL_W-1:0]     value;
		logic [LEVEL_W-1:0]   level;
		logic [OUT_CNT_W-1:0] l1_hits;
		logic [OUT_CNT_W-1:0] l2_hits;
		logic [OUT_CNT_W-1:0] misses;
		logic [VCNT_W-1:0]    vcount;
	} lookup_t;

	typedef struct packed {
		logic [KEY_W-1:0] word;
		logic             lst;
		logic [VAL_W-1:0] fresh;
		logic             typed;
		lookup_t          want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [KEY_W-1:0]     key_word;
	logic                 last;
	logic [VAL_W-1:0]     miss_value;
	logic                 done;
	logic [VAL_W-1:0]     cached_value;
	logic [LEVEL_W-1:0]   hit_level;
	logic [OUT_CNT_W-1:0] l1_hit_total;
	logic [OUT_CNT_W-1:0] l2_hit_total;
	logic [OUT_CNT_W-1:0] miss_total;
	logic [VCNT_W-1:0]    l2_valid_count;

	two_level_keyed_memo_cache_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.key_word       (key_word),
		.last           (last),
		.miss_value     (miss_value),
		.done           (done),
		.cached_value   (cached_value),
		.hit_level      (hit_level),
		.l1_hit_total   (l1_hit_total),
		.l2_hit_total   (l2_hit_total),
		.miss_total     (miss_total),
		.l2_valid_count (l2_valid_count)
	);

	// predictor state
	logic [KEY_W-1:0]     fingerprint;
	logic                 near_ok;
	logic [KEY_W-1:0]     near_tag;
	logic [VAL_W-1:0]     near_val;
	logic [FAR_SLOTS-1:0] far_ok;
	logic [KEY_W-1:0]     far_tag [FAR_SLOTS];
	logic [VAL_W-1:0]     far_val [FAR_SLOTS];
	int unsigned          next_slot;
	logic [OUT_CNT_W-1:0] near_cnt, far_cnt, miss_cnt;

	lookup_t     lookups_due[$];
	int unsigned errors;
	int unsigned sent;
	int unsigned beats_seen, near_seen, far_seen, miss_seen;
	bit          idle_ok;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("two_level_keyed_memo_cache_core test failed");
		$finish;
	end

	function automatic logic [OUT_CNT_W-1:0] sat_bump(input logic [OUT_CNT_W-1:0] c);
		return (c == '1) ? c : c + OUT_CNT_W'(1);
	endfunction

	task automatic fold_and_lookup(input logic [KEY_W-1:0] w, input logic lst,
			input logic [VAL_W-1:0] fresh, output bit produced, output lookup_t res);
		logic [KEY_W-1:0] fp;
		bit               found;
		int unsigned      slot;
		fingerprint = fingerprint ^ (w + GOLDEN_STEP + (fingerprint << SHL_AMT)
			+ (fingerprint >> SHR_AMT));
		produced = lst;
		res = '0;
		if (!lst)
			return;
		fp = fingerprint;
		fingerprint = FNV_BASIS;
		if (near_ok && near_tag == fp) begin
			near_cnt = sat_bump(near_cnt);
			res.value = near_val;
			res.level = LVL_NEAR;
		end else begin
			found = 1'b0;
			for (int i = 0; i < FAR_SLOTS; i++) begin
				if (!found && far_ok[i] && far_tag[i] == fp) begin
					found = 1'b1;
					near_ok = 1'b1;
					near_tag = fp;
					near_val = far_val[i];
					far_cnt = sat_bump(far_cnt);
					res.value = far_val[i];
					res.level = LVL_FAR;
				end
			end
			if (!found) begin
				slot = next_slot;
				near_ok = 1'b1;
				near_tag = fp;
				near_val = fresh;
				far_ok[slot] = 1'b1;
				far_tag[slot] = fp;
				far_val[slot] = fresh;
				next_slot = (slot == FAR_SLOTS - 1) ? 0 : slot + 1;
				miss_cnt = sat_bump(miss_cnt);
				res.value = fresh;
				res.level = LVL_MISS;
			end
		end
		res.l1_hits = near_cnt;
		res.l2_hits = far_cnt;
		res.misses = miss_cnt;
		res.vcount = VCNT_W'($countones(far_ok));
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("MISMATCH t=%0t beat %0d %s: got %h want %h", $realtime, beats_seen,
			field, got, want);
	endtask

	task automatic send_beat(input logic [KEY_W-1:0] w, input logic lst,
			input logic [VAL_W-1:0] fresh, input logic typed, input lookup_t want);
		bit      produced;
		lookup_t res;
		start <= 1'b1;
		key_word <= w;
		last <= lst;
		miss_value <= fresh;
		do @(posedge clk); while (busy);
		fold_and_lookup(w, lst, fresh, produced, res);
		if (produced)
			lookups_due.push_back(typed ? want : res);
		sent++;
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (lookups_due.size() != 0) @(posedge clk);
	endtask

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		lookup_t exp_res;
		if (arst_n && done) begin
			beats_seen++;
			case (hit_level)
				LVL_NEAR: near_seen++;
				LVL_FAR:  far_seen++;
				default:  miss_seen++;
			endcase
			if (lookups_due.size() == 0) begin
				report_mismatch("unexpected beat", cached_value, '0);
			end else begin
				exp_res = lookups_due.pop_front();
				if (cached_value !== exp_res.value)
					report_mismatch("cached_value", cached_value, exp_res.value);
				if (hit_level !== exp_res.level)
					report_mismatch("hit_level", hit_level, exp_res.level);
				if (l1_hit_total !== exp_res.l1_hits)
					report_mismatch("l1_hit_total", l1_hit_total, exp_res.l1_hits);
				if (l2_hit_total !== exp_res.l2_hits)
					report_mismatch("l2_hit_total", l2_hit_total, exp_res.l2_hits);
				if (miss_total !== exp_res.misses)
					report_mismatch("miss_total", miss_total, exp_res.misses);
				if (l2_valid_count !== exp_res.vcount)
					report_mismatch("l2_valid_count", l2_valid_count, exp_res.vcount);
			end
		end
	end

	initial begin
		stim_row_t   directed [16];
		logic [63:0] pool_word [POOL_KEYS][3];
		int unsigned pool_len [POOL_KEYS];
		int unsigned pick, prev, mode, n;
		bit          drained;

		fingerprint = FNV_BASIS;
		near_ok = 1'b0;
		near_tag = '0;
		near_val = '0;
		far_ok = '0;
		next_slot = 0;
		near_cnt = '0;
		far_cnt = '0;
		miss_cnt = '0;
		errors = 0;
		sent = 0;
		beats_seen = 0;
		near_seen = 0;
		far_seen = 0;
		miss_seen = 0;
		idle_ok = 1'b1;
		drained = 1'b0;
		prev = 0;

		arst_n <= 1'b0;
		start <= 1'b0;
		key_word <= '0;
		last <= 1'b0;
		miss_value <= '0;

		directed = '{
			'{64'h0, 1'b1, ONES, 1'b1, '{ONES, LVL_MISS, 32'd0, 32'd0, 32'd1, 5'd1}},
			'{64'h0, 1'b1, 64'h0, 1'b1, '{ONES, LVL_NEAR, 32'd1, 32'd0, 32'd1, 5'd1}},
			'{ONES, 1'b1, 64'h0, 1'b1, '{64'h0, LVL_MISS, 32'd1, 32'd0, 32'd2, 5'd2}},
			'{64'h0, 1'b1, 64'h0, 1'b1, '{ONES, LVL_FAR, 32'd1, 32'd1, 32'd2, 5'd2}},
			'{ONES, 1'b1, ONES, 1'b1, '{64'h0, LVL_FAR, 32'd1, 32'd2, 32'd2, 5'd2}},
			'{64'h1, 1'b0, ONES, 1'b0, '0},
			'{ONES, 1'b0, 64'h0, 1'b0, '0},
			'{64'h8000_0000_0000_0000, 1'b1, 64'h0123_4567_89ab_cdef, 1'b0, '0},
			'{64'h1, 1'b0, 64'h0, 1'b0, '0},
			'{ONES, 1'b0, 64'h0, 1'b0, '0},
			'{64'h8000_0000_0000_0000, 1'b1, 64'h0, 1'b0, '0},
			'{64'h5555_5555_5555_5555, 1'b0, ONES, 1'b0, '0},
			'{64'haaaa_aaaa_aaaa_aaaa, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
			'{64'h1, 1'b0, 64'h5555_5555_5555_5555, 1'b0, '0},
			'{ONES, 1'b0, 64'h0, 1'b0, '0},
			'{64'h8000_0000_0000_0000, 1'b1, ONES, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_beat(directed[i].word, directed[i].lst, directed[i].fresh,
				directed[i].typed, directed[i].want);
		wait_idle();

		for (int k = 0; k < POOL_KEYS; k++) begin
			pool_len[k] = $urandom_range(1, 3);
			for (int j = 0; j < 3; j++)
				pool_word[k][j] = {$urandom, $urandom};
		end

		while (sent < ITEMS) begin
			idle_ok = (sent < CALM_FROM) && ((sent / 40) % 3 != 2);
			if (!drained && sent >= DRAIN_AT) begin
				wait_idle();
				drained = 1'b1;
			end
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				send_beat({$urandom, $urandom}, 1'($urandom_range(0, 1)),
					{$urandom, $urandom}, 1'b0, '0);
			end else if (mode == 1) begin
				// broken sequence: cut a pooled key short with a stray word
				pick = $urandom_range(0, POOL_KEYS - 1);
				n = $urandom_range(0, pool_len[pick] - 1);
				for (int j = 0; j < n; j++)
					send_beat(pool_word[pick][j], 1'b0, {$urandom, $urandom}, 1'b0, '0);
				send_beat({$urandom, $urandom}, 1'b1, {$urandom, $urandom}, 1'b0, '0);
			end else begin
				pick = ($urandom_range(0, 4) == 0) ? prev : $urandom_range(0, POOL_KEYS - 1);
				prev = pick;
				for (int j = 0; j < pool_len[pick]; j++)
					send_beat(pool_word[pick][j], 1'(j == pool_len[pick] - 1),
						{$urandom, $urandom}, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (TAIL) @(posedge clk);

		$display("Covered %0d key words and %0d lookups: %0d L1 hits, %0d L2 hits, %0d misses",
			sent, beats_seen, near_seen, far_seen, miss_seen);
		$display("Field mismatches: %0d", errors);
		if (errors == 0)
			$display("two_level_keyed_memo_cache_core test passed");
		else
			$display("two_level_keyed_memo_cache_core test failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/tlkmc_pkg.sv
rtl/tlkmc_alu.sv
rtl/tlkmc_far_mem.sv
rtl/two_level_keyed_memo_cache_core.sv
dv/tb.sv
